// ===== rtl/pptrk_pkg.sv =====
// ----------------------------------------------------------------------------
// pptrk_pkg
// shared types and constants for the profile peak tracker
// ----------------------------------------------------------------------------
package pptrk_pkg;

  // profile geometry
  localparam int PROFILE_LEN = 4096;
  localparam int IDX_W       = $clog2(PROFILE_LEN);
  localparam int CNT_W       = $clog2(PROFILE_LEN) + 1;

  // field widths
  localparam int DENS_W  = 16;
  localparam int SLOPE_W = 24;
  localparam int NORM_W  = 13;
  localparam int LOC_W   = 12;
  localparam int WGT_W   = 16;
  localparam int LIMIT_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  // arithmetic widths
  localparam int FRAC_W    = 16;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int TERM_W    = DIV_W + 2;
  localparam int PROD_W    = 2 * SLOPE_W;
  localparam int ACC_W     = 52;
  localparam int SCORE_W   = ACC_W - FRAC_W;

  // payload widths on the stream ports
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  // register reset values
  localparam logic [DENS_W-1:0]         DENSITY_THRESHOLD_RST = DENS_W'(80);
  localparam logic signed [LIMIT_W-1:0] SLOPE_LIMIT_RST       = '0;
  localparam logic [NORM_W-1:0]         FRAME_WIDTH_RST       = NORM_W'(640);
  localparam logic [NORM_W-1:0]         FRAME_HEIGHT_RST      = NORM_W'(480);
  localparam logic [LOC_W-1:0]          MIN_SEPARATION_RST    = LOC_W'(10);
  localparam logic [LOC_W-1:0]          FALLBACK_LOCATION_RST = LOC_W'(639);
  localparam logic [WGT_W-1:0]          LOCATION_WEIGHT_RST   = WGT_W'(32768);
  localparam logic [WGT_W-1:0]          DENSITY_WEIGHT_RST    = WGT_W'(32768);

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DENSITY_THRESHOLD = 3'd0,
    REG_SLOPE_LIMIT       = 3'd1,
    REG_FRAME_WIDTH       = 3'd2,
    REG_FRAME_HEIGHT      = 3'd3,
    REG_MIN_SEPARATION    = 3'd4,
    REG_FALLBACK_LOCATION = 3'd5,
    REG_LOCATION_WEIGHT   = 3'd6,
    REG_DENSITY_WEIGHT    = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_TEST,
    ST_DLOAD,
    ST_DIV,
    ST_TERM,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_UPDATE,
    ST_ADVANCE
  } state_t;

endpackage

// ===== rtl/pptrk_div.sv =====
// ----------------------------------------------------------------------------
// pptrk_div
// restoring divider, one quotient bit per cycle, zero divisor acts as one
// ----------------------------------------------------------------------------
module pptrk_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pptrk_pkg::DIV_W-1:0]  dividend,
  input  logic [pptrk_pkg::NORM_W-1:0] divisor,
  output logic                         done,
  output logic [pptrk_pkg::DIV_W-1:0]  quotient
);
  import pptrk_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     qd;
  logic [NORM_W-1:0]    rem;
  logic [NORM_W-1:0]    dsr;
  logic [NORM_W:0]      shifted;
  logic [NORM_W:0]      diff;
  logic                 ge;

  assign shifted  = {rem, qd[DIV_W-1]};
  assign ge       = shifted >= {1'b0, dsr};
  assign diff     = shifted - {1'b0, dsr};
  assign quotient = qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qd  <= dividend;
      rem <= '0;
      dsr <= (divisor == '0) ? NORM_W'(1) : divisor;
    end else if (busy) begin
      qd  <= {qd[DIV_W-2:0], ge};
      rem <= ge ? diff[NORM_W-1:0] : shifted[NORM_W-1:0];
    end
  end

endmodule

// ===== rtl/profile_peak_tracker.sv =====
// ----------------------------------------------------------------------------
// profile_peak_tracker
// peak search over one frame's smoothed profile with next-frame prediction
// ----------------------------------------------------------------------------
// One input beat is one profile sample (density, Q15.8 slope, tlast on the
// final sample of the frame). A sample other than the first of a frame is a
// peak when its density reaches density_threshold, previous*current slope is
// below slope_product_limit and the slope falls. Each peak is scored against
// the prior primary and secondary predictions and the best of each is kept.
// The tlast sample emits one output beat with the new predictions and the
// peak count. A sample is taken only while the block is idle; s_tready stays
// low until the sample is finished. A peak sample is scored by the single
// radix-2 divider, which runs four 32-bit divisions by the frame size
// registers, one quotient bit per cycle. The tlast sample waits in its final
// step while a previous output beat is still held in the output register.
// No clearing pass after reset; configuration writes are taken at any time.
module profile_peak_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pptrk_pkg::IN_DATA_W-1:0]      s_tdata,   // density[15:0], slope[39:16]
  input  logic                                 s_tlast,   // last sample of the frame
  // prediction stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // primary_location[11:0], secondary_location[23:12], primary_density[39:24],
  // secondary_density[55:40], peak_count[68:56], zero fill [71:69]
  output logic [pptrk_pkg::OUT_DATA_W-1:0]     m_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pptrk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pptrk_pkg::CFG_W-1:0]          cfg_data
);
  import pptrk_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DENS_W-1:0]         density_threshold;
  logic signed [LIMIT_W-1:0] slope_product_limit;
  logic [NORM_W-1:0]         frame_width;
  logic [NORM_W-1:0]         frame_height;
  logic [LOC_W-1:0]          min_separation;
  logic [LOC_W-1:0]          fallback_location;
  logic [WGT_W-1:0]          location_weight;
  logic [WGT_W-1:0]          density_weight;

  // always able to take a register write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      density_threshold   <= DENSITY_THRESHOLD_RST;
      slope_product_limit <= SLOPE_LIMIT_RST;
      frame_width         <= FRAME_WIDTH_RST;
      frame_height        <= FRAME_HEIGHT_RST;
      min_separation      <= MIN_SEPARATION_RST;
      fallback_location   <= FALLBACK_LOCATION_RST;
      location_weight     <= LOCATION_WEIGHT_RST;
      density_weight      <= DENSITY_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DENSITY_THRESHOLD: density_threshold   <= cfg_data[DENS_W-1:0];
        REG_SLOPE_LIMIT:       slope_product_limit <= $signed(cfg_data[LIMIT_W-1:0]);
        REG_FRAME_WIDTH:       frame_width         <= cfg_data[NORM_W-1:0];
        REG_FRAME_HEIGHT:      frame_height        <= cfg_data[NORM_W-1:0];
        REG_MIN_SEPARATION:    min_separation      <= cfg_data[LOC_W-1:0];
        REG_FALLBACK_LOCATION: fallback_location   <= cfg_data[LOC_W-1:0];
        REG_LOCATION_WEIGHT:   location_weight     <= cfg_data[WGT_W-1:0];
        REG_DENSITY_WEIGHT:    density_weight      <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t state, state_next;

  // captured sample
  logic [DENS_W-1:0]         density_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic                      last_q;

  // per-frame tracking
  logic signed [SLOPE_W-1:0] previous_slope;
  logic [IDX_W-1:0]          sample_index;
  logic [CNT_W-1:0]          peaks_found;
  logic signed [SCORE_W-1:0] best_primary_score;
  logic signed [SCORE_W-1:0] best_secondary_score;
  logic [IDX_W-1:0]          best_primary_position;
  logic [DENS_W-1:0]         best_primary_weight;
  logic [IDX_W-1:0]          best_secondary_position;
  logic [DENS_W-1:0]         best_secondary_weight;

  // predictions carried across frames
  logic [IDX_W-1:0]          prior_primary_position;
  logic [IDX_W-1:0]          prior_secondary_position;
  logic [DENS_W-1:0]         prior_primary_weight;
  logic [DENS_W-1:0]         prior_secondary_weight;

  // scoring datapath
  logic [1:0]                term_idx;    // 0/1 primary loc/dens, 2/3 secondary
  logic signed [TERM_W-1:0]  term_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [SCORE_W-1:0] primary_score;
  logic signed [SCORE_W-1:0] secondary_score;

  // output register
  logic [LOC_W-1:0]          out_primary_location;
  logic [LOC_W-1:0]          out_secondary_location;
  logic [DENS_W-1:0]         out_primary_density;
  logic [DENS_W-1:0]         out_secondary_density;
  logic [CNT_W-1:0]          out_peak_count;

  // control from the sequencer
  logic                      div_start;
  logic                      adv_go;
  logic signed [SLOPE_W-1:0] mul_a;
  logic signed [SLOPE_W-1:0] mul_b;

  // shared divider
  logic                      div_done;
  logic [DIV_W-1:0]          div_quotient;
  logic [DIV_W-1:0]          div_dividend;
  logic [NORM_W-1:0]         div_divisor;

  function automatic logic [LOC_W-1:0] diff_loc(input logic [LOC_W-1:0] a,
                                                input logic [LOC_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DENS_W-1:0] diff_dens(input logic [DENS_W-1:0] a,
                                                  input logic [DENS_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // --------------------------------------------------------------------------
  // peak test and operand selection
  // --------------------------------------------------------------------------
  logic             is_peak;
  logic [LOC_W-1:0] secondary_ref;
  logic [DENS_W-1:0] div_num;
  logic [WGT_W-1:0] weight_sel;

  // prod_q holds previous_slope * slope once the sequencer reaches the test
  assign is_peak = (sample_index != '0)
                && (density_q >= density_threshold)
                && (prod_q < PROD_W'(slope_product_limit))
                && (previous_slope > slope_q);

  // priors that sit too close together score the secondary at the fallback
  assign secondary_ref =
    (diff_loc(prior_primary_position, prior_secondary_position) < min_separation)
      ? fallback_location : prior_secondary_position;

  // per term: numerator and normaliser (secondary uses the swapped pair)
  always_comb begin
    case (term_idx)
      2'd0: begin
        div_num     = DENS_W'(diff_loc(prior_primary_position, sample_index));
        div_divisor = frame_width;
      end
      2'd1: begin
        div_num     = diff_dens(prior_primary_weight, density_q);
        div_divisor = frame_height;
      end
      2'd2: begin
        div_num     = DENS_W'(diff_loc(secondary_ref, sample_index));
        div_divisor = frame_height;
      end
      default: begin
        div_num     = diff_dens(prior_secondary_weight, density_q);
        div_divisor = frame_width;
      end
    endcase
  end

  assign div_dividend = {div_num, FRAC_W'(0)};
  assign weight_sel   = term_idx[0] ? density_weight : location_weight;

  pptrk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_SLOPE;
      ST_SLOPE:   state_next = ST_TEST;
      ST_TEST:    state_next = is_peak ? ST_DLOAD : ST_ADVANCE;
      ST_DLOAD:   state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_TERM;
      ST_TERM:    state_next = ST_MLO;
      ST_MLO:     state_next = ST_MHI;
      ST_MHI:     state_next = ST_ACC;
      ST_ACC:     state_next = (term_idx == 2'd3) ? ST_UPDATE : ST_DLOAD;
      ST_UPDATE:  state_next = ST_ADVANCE;
      ST_ADVANCE: if (adv_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    adv_go    = 1'b0;
    mul_a     = previous_slope;
    mul_b     = slope_q;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_DLOAD: div_start = 1'b1;
      // weight times low 16 bits of the term, then times the signed upper part
      ST_MLO: begin
        mul_a = $signed({{(SLOPE_W-FRAC_W){1'b0}}, term_q[FRAC_W-1:0]});
        mul_b = $signed({{(SLOPE_W-WGT_W){1'b0}}, weight_sel});
      end
      ST_MHI: begin
        mul_a = $signed({{(SLOPE_W-TERM_W+FRAC_W){term_q[TERM_W-1]}},
                         term_q[TERM_W-1:FRAC_W]});
        mul_b = $signed({{(SLOPE_W-WGT_W){1'b0}}, weight_sel});
      end
      // a frame end holds here until the output register is free
      ST_ADVANCE: adv_go = !last_q || !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  // running sum of the two weighted terms; upper product enters shifted by 16
  always_comb begin
    acc_sum = acc_q + ($signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}) <<< FRAC_W);
  end

  // captured sample and arithmetic registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      density_q <= s_tdata[DENS_W-1:0];
      slope_q   <= $signed(s_tdata[DENS_W+SLOPE_W-1:DENS_W]);
      last_q    <= s_tlast;
    end
    // the one multiplier: slope product first, then the weight products
    prod_q <= mul_a * mul_b;
    if (state == ST_TERM) begin
      term_q <= $signed(TERM_W'(1) <<< FRAC_W) - $signed({2'b00, div_quotient});
    end
    if (state == ST_TEST) begin
      acc_q <= '0;
    end else if (state == ST_MHI) begin
      acc_q <= acc_q + $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
    end else if (state == ST_ACC) begin
      // floor shift: arithmetic shift of the two's complement sum
      if (term_idx == 2'd1) primary_score   <= acc_sum[ACC_W-1:FRAC_W];
      if (term_idx == 2'd3) secondary_score <= acc_sum[ACC_W-1:FRAC_W];
      acc_q <= term_idx[0] ? '0 : acc_sum;
    end
  end

  // term counter
  always_ff @(posedge clk) begin
    if (rst) begin
      term_idx <= '0;
    end else if (state == ST_TEST) begin
      term_idx <= '0;
    end else if (state == ST_ACC) begin
      term_idx <= term_idx + 1'b1;
    end
  end

  // frame tracking, predictions and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_slope           <= '0;
      sample_index             <= '0;
      peaks_found              <= '0;
      best_primary_score       <= '0;
      best_secondary_score     <= '0;
      best_primary_position    <= '0;
      best_primary_weight      <= '0;
      best_secondary_position  <= '0;
      best_secondary_weight    <= '0;
      prior_primary_position   <= '0;
      prior_secondary_position <= '0;
      prior_primary_weight     <= '0;
      prior_secondary_weight   <= '0;
      m_tvalid                 <= 1'b0;
    end else begin
      // a new beat may replace one that leaves on this same edge
      if (adv_go && last_q) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // keep the strictly better peak, the first one in a frame always
      if (state == ST_UPDATE) begin
        if (peaks_found == '0 || primary_score > best_primary_score) begin
          best_primary_score    <= primary_score;
          best_primary_position <= sample_index;
          best_primary_weight   <= density_q;
        end
        if (peaks_found == '0 || secondary_score > best_secondary_score) begin
          best_secondary_score    <= secondary_score;
          best_secondary_position <= sample_index;
          best_secondary_weight   <= density_q;
        end
        if (peaks_found < CNT_W'(PROFILE_LEN)) peaks_found <= peaks_found + 1'b1;
      end

      if (adv_go) begin
        if (last_q) begin
          // predictions move only when the frame had a peak
          if (peaks_found != '0) begin
            prior_primary_position   <= best_primary_position;
            prior_secondary_position <= best_secondary_position;
            prior_primary_weight     <= best_primary_weight;
            prior_secondary_weight   <= best_secondary_weight;
          end

          // start the next frame clean
          previous_slope          <= '0;
          sample_index            <= '0;
          peaks_found             <= '0;
          best_primary_score      <= '0;
          best_secondary_score    <= '0;
          best_primary_position   <= '0;
          best_primary_weight     <= '0;
          best_secondary_position <= '0;
          best_secondary_weight   <= '0;
        end else begin
          previous_slope <= slope_q;
          // position saturates on an over-long profile
          if (sample_index != IDX_W'(PROFILE_LEN - 1)) sample_index <= sample_index + 1'b1;
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv_go && last_q) begin
      if (peaks_found != '0) begin
        out_primary_location   <= best_primary_position;
        out_secondary_location <= best_secondary_position;
        out_primary_density    <= best_primary_weight;
        out_secondary_density  <= best_secondary_weight;
      end else begin
        out_primary_location   <= prior_primary_position;
        out_secondary_location <= prior_secondary_position;
        out_primary_density    <= prior_primary_weight;
        out_secondary_density  <= prior_secondary_weight;
      end
      out_peak_count <= peaks_found;
    end
  end

  assign m_tdata = {3'b000, out_peak_count, out_secondary_density, out_primary_density,
                    out_secondary_location, out_primary_location};

endmodule

// ===== rtl/pptrk_chk.sv =====
// ----------------------------------------------------------------------------
// pptrk_chk
// port-level checks for the profile peak tracker, bound to the top level
// ----------------------------------------------------------------------------
module pptrk_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [pptrk_pkg::IN_DATA_W-1:0]      s_tdata,
  input logic                                 s_tlast,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [pptrk_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [pptrk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [pptrk_pkg::CFG_W-1:0]          cfg_data
);
  import pptrk_pkg::*;

  logic unused_inputs;
  assign unused_inputs = ^{s_tdata, s_tlast, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // one sample at a time: busy right after a sample beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample taken on back-to-back cycles");

  // a prediction only appears as the block finishes a sample
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("prediction beat raised while idle");

  // peak count in range, fill bits zero
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[68:56] <= 13'(PROFILE_LEN)) && (m_tdata[71:69] == 3'b000))
    else $error("peak count out of range");

  // held prediction beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("prediction beat changed while stalled");

endmodule

bind profile_peak_tracker pptrk_chk u_pptrk_chk (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tlast   (s_tlast),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
